/* hw/rtl/hid2ps2_pkg.sv */
// Shared types, codes and the usage-to-scancode table of the HID to PS/2 translator.
`default_nettype none

package hid2ps2_pkg;

  localparam logic [7:0] PauseUsage = 8'h48;
  localparam logic [7:0] PrtscUsage = 8'h46;
  localparam logic [7:0] PrefixExt  = 8'hE0;
  localparam logic [7:0] BreakMark  = 8'hF0;
  localparam int unsigned MaxBytes  = 8;
  localparam int unsigned IdxW      = $clog2(MaxBytes);
  localparam int unsigned LenW      = $clog2(MaxBytes + 1);

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ONE,
    KIND_EXT,
    KIND_PRTSC,
    KIND_PAUSE
  } key_kind_e;

  typedef struct packed {
    key_kind_e  kind;
    logic [7:0] code;
  } rom_entry_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [LenW-1:0]          len;
  } seq_t;

  // Table entry: bit 8 = E0 prefix, low byte = make code, 0 = no key.
  function automatic logic [8:0] table_entry(input logic [7:0] usage);
    logic [8:0] e;
    case (usage)
      8'h04: e = 9'h01C;  8'h05: e = 9'h032;  8'h06: e = 9'h021;  8'h07: e = 9'h023;
      8'h08: e = 9'h024;  8'h09: e = 9'h02B;  8'h0A: e = 9'h034;  8'h0B: e = 9'h033;
      8'h0C: e = 9'h043;  8'h0D: e = 9'h03B;  8'h0E: e = 9'h042;  8'h0F: e = 9'h04B;
      8'h10: e = 9'h03A;  8'h11: e = 9'h031;  8'h12: e = 9'h044;  8'h13: e = 9'h04D;
      8'h14: e = 9'h015;  8'h15: e = 9'h02D;  8'h16: e = 9'h01B;  8'h17: e = 9'h02C;
      8'h18: e = 9'h03C;  8'h19: e = 9'h02A;  8'h1A: e = 9'h01D;  8'h1B: e = 9'h022;
      8'h1C: e = 9'h035;  8'h1D: e = 9'h01A;  8'h1E: e = 9'h016;  8'h1F: e = 9'h01E;
      8'h20: e = 9'h026;  8'h21: e = 9'h025;  8'h22: e = 9'h02E;  8'h23: e = 9'h036;
      8'h24: e = 9'h03D;  8'h25: e = 9'h03E;  8'h26: e = 9'h046;  8'h27: e = 9'h045;
      8'h28: e = 9'h05A;  8'h29: e = 9'h076;  8'h2A: e = 9'h066;  8'h2B: e = 9'h00D;
      8'h2C: e = 9'h029;  8'h2D: e = 9'h04E;  8'h2E: e = 9'h055;  8'h2F: e = 9'h054;
      8'h30: e = 9'h05B;  8'h31: e = 9'h05D;  8'h32: e = 9'h02F;  8'h33: e = 9'h04C;
      8'h34: e = 9'h052;  8'h35: e = 9'h00E;  8'h36: e = 9'h041;  8'h37: e = 9'h049;
      8'h38: e = 9'h04A;  8'h39: e = 9'h058;  8'h3A: e = 9'h005;  8'h3B: e = 9'h006;
      8'h3C: e = 9'h004;  8'h3D: e = 9'h00C;  8'h3E: e = 9'h003;  8'h3F: e = 9'h00B;
      8'h40: e = 9'h083;  8'h41: e = 9'h00A;  8'h42: e = 9'h001;  8'h43: e = 9'h009;
      8'h44: e = 9'h078;  8'h45: e = 9'h007;  8'h47: e = 9'h07E;
      8'h49: e = 9'h170;  8'h4A: e = 9'h16C;  8'h4B: e = 9'h17D;
      8'h4C: e = 9'h171;  8'h4D: e = 9'h169;  8'h4E: e = 9'h17A;  8'h4F: e = 9'h174;
      8'h50: e = 9'h16B;  8'h51: e = 9'h172;  8'h52: e = 9'h175;  8'h53: e = 9'h077;
      8'h54: e = 9'h14A;  8'h55: e = 9'h07C;  8'h56: e = 9'h07B;  8'h57: e = 9'h079;
      8'h58: e = 9'h15A;  8'h59: e = 9'h069;  8'h5A: e = 9'h072;  8'h5B: e = 9'h07A;
      8'h5C: e = 9'h06B;  8'h5D: e = 9'h073;  8'h5E: e = 9'h074;  8'h5F: e = 9'h06C;
      8'h60: e = 9'h075;  8'h61: e = 9'h07D;  8'h62: e = 9'h070;  8'h63: e = 9'h071;
      8'hE0: e = 9'h014;  8'hE1: e = 9'h012;  8'hE2: e = 9'h011;  8'hE3: e = 9'h11F;
      8'hE4: e = 9'h114;  8'hE5: e = 9'h059;  8'hE6: e = 9'h111;  8'hE7: e = 9'h127;
      default: e = 9'h000;
    endcase
    return e;
  endfunction

  function automatic rom_entry_t lookup(input logic [7:0] usage);
    rom_entry_t r;
    logic [8:0] e;
    e      = table_entry(usage);
    r.code = e[7:0];
    if (usage == PrtscUsage) begin
      r.kind = KIND_PRTSC;
    end else if (usage == PauseUsage) begin
      r.kind = KIND_PAUSE;
    end else if (e == 9'h000) begin
      r.kind = KIND_NONE;
    end else if (e[8]) begin
      r.kind = KIND_EXT;
    end else begin
      r.kind = KIND_ONE;
    end
    return r;
  endfunction

  // Byte sequence for one event, first byte at index 0.
  function automatic seq_t build_seq(input rom_entry_t ent, input logic brk);
    seq_t s;
    s.bytes = '0;
    s.len   = '0;
    case (ent.kind)
      KIND_ONE: begin
        if (brk) begin
          s.bytes[0] = BreakMark;
          s.bytes[1] = ent.code;
          s.len      = LenW'(2);
        end else begin
          s.bytes[0] = ent.code;
          s.len      = LenW'(1);
        end
      end
      KIND_EXT: begin
        s.bytes[0] = PrefixExt;
        if (brk) begin
          s.bytes[1] = BreakMark;
          s.bytes[2] = ent.code;
          s.len      = LenW'(3);
        end else begin
          s.bytes[1] = ent.code;
          s.len      = LenW'(2);
        end
      end
      KIND_PRTSC: begin
        s.bytes[0] = PrefixExt;
        if (brk) begin
          s.bytes[1] = BreakMark;
          s.bytes[2] = 8'h12;
          s.bytes[3] = PrefixExt;
          s.bytes[4] = 8'h7C;
          s.len      = LenW'(5);
        end else begin
          s.bytes[1] = 8'h12;
          s.bytes[2] = PrefixExt;
          s.bytes[3] = 8'h7C;
          s.len      = LenW'(4);
        end
      end
      KIND_PAUSE: begin
        // No release sequence for Pause.
        if (!brk) begin
          s.bytes[0] = 8'hE1;
          s.bytes[1] = 8'h14;
          s.bytes[2] = 8'h77;
          s.bytes[3] = 8'hE1;
          s.bytes[4] = BreakMark;
          s.bytes[5] = 8'h14;
          s.bytes[6] = PrefixExt;
          s.bytes[7] = 8'h77;
          s.len      = LenW'(MaxBytes);
        end
      end
      default: begin
        s.len = '0;
      end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/hid2ps2_rom.sv */
// Scancode table with a registered read port.
`default_nettype none

module hid2ps2_rom
  import hid2ps2_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rd_en_i,
  input  wire logic [7:0] usage_i,
  input  wire logic       brk_i,
  output rom_entry_t      entry_o,
  output logic            brk_o
);

  rom_entry_t entry_q;
  logic       brk_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      entry_q <= lookup(usage_i);
      brk_q   <= brk_i;
    end
  end

  assign entry_o = entry_q;
  assign brk_o   = brk_q;

endmodule

`default_nettype wire

/* hw/rtl/usb_hid_to_ps2_scancode_top.sv */
// Top level: USB HID key event in, PS/2 set-2 scancode bytes out.
//
// Usage:
//   Slave side takes one key request per handshake: s_tdata_i carries the
//   HID usage code, s_tuser_i is the break flag (1 = release).
//   Master side gives the key's scancode bytes one per handshake on m_tdata_o, with
//   m_tlast_o high on the final byte of that key's sequence.
//   Unmapped usages and a Pause release produce no output at all.
// Flow: a request accepted on the slave side is looked up in the table ROM,
//   expanded into the byte sequencer, and its bytes leave through the
//   output register to the master side.
// Throughput: one output byte per cycle while m_tready_i is high; a key
//   has 1 to 8 bytes, sent in order by the single-byte sequencer. A key with no
//   bytes still passes the hand-over. The next key is looked up while
//   the current one drains, so keys follow back to back.
// Reset: rst_ni clears all valid flags; no output is pending after reset.
// Stall: when m_tready_i is low the output register holds its byte, the
//   sequencer waits, and one further request can be held in the lookup
//   stage before s_tready_o drops.
`default_nettype none

module usb_hid_to_ps2_scancode_top
  import hid2ps2_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // slave request channel
  input  wire logic       s_tvalid_i,
  output logic            s_tready_o,
  input  wire logic [7:0] s_tdata_i,   // [7:0] usb_code
  input  wire logic       s_tuser_i,   // [0] key_release
  // master byte channel
  output logic            m_tvalid_o,
  input  wire logic       m_tready_i,
  output logic [7:0]      m_tdata_o,   // [7:0] scan_byte
  output logic            m_tlast_o    // last_byte
);

  // Handshake and stage control
  logic s_accept;
  logic out_free;
  logic emit;
  logic seq_last;
  logic seq_done;
  logic seq_load_ok;
  logic lk_adv;

  // Lookup stage
  logic       lk_valid_q, lk_valid_d;
  rom_entry_t lk_entry;
  logic       lk_brk;
  seq_t       new_seq;

  // Sequencer stage
  logic                     seq_busy_q, seq_busy_d;
  logic [MaxBytes-1:0][7:0] seq_bytes_q, seq_bytes_d;
  logic [LenW-1:0]          seq_len_q, seq_len_d;
  logic [IdxW-1:0]          seq_idx_q, seq_idx_d;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_data_q, out_data_d;
  logic       out_last_q, out_last_d;

  assign out_free    = !out_valid_q || m_tready_i;
  assign emit        = seq_busy_q && out_free;
  assign seq_last    = (LenW'(seq_idx_q) + LenW'(1)) == seq_len_q;
  assign seq_done    = emit && seq_last;
  assign seq_load_ok = !seq_busy_q || seq_done;
  assign lk_adv      = lk_valid_q && seq_load_ok;
  assign s_tready_o  = !lk_valid_q || seq_load_ok;
  assign s_accept    = s_tvalid_i && s_tready_o;

  hid2ps2_rom u_rom (
    .clk_i   (clk_i),
    .rd_en_i (s_accept),
    .usage_i (s_tdata_i),
    .brk_i   (s_tuser_i),
    .entry_o (lk_entry),
    .brk_o   (lk_brk)
  );

  assign new_seq = build_seq(lk_entry, lk_brk);

  always_comb begin
    lk_valid_d = lk_valid_q;
    if (s_accept) begin
      lk_valid_d = 1'b1;
    end else if (lk_adv) begin
      lk_valid_d = 1'b0;
    end
  end

  // Events with an empty sequence are dropped at the hand-over.
  always_comb begin
    seq_busy_d  = seq_busy_q;
    seq_bytes_d = seq_bytes_q;
    seq_len_d   = seq_len_q;
    seq_idx_d   = seq_idx_q;
    if (lk_adv) begin
      seq_busy_d  = (new_seq.len != '0);
      seq_bytes_d = new_seq.bytes;
      seq_len_d   = new_seq.len;
      seq_idx_d   = '0;
    end else if (seq_done) begin
      seq_busy_d = 1'b0;
    end else if (emit) begin
      seq_idx_d = seq_idx_q + IdxW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_data_d  = seq_bytes_q[seq_idx_q];
      out_last_d  = seq_last;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_valid_q  <= 1'b0;
      seq_busy_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      lk_valid_q  <= lk_valid_d;
      seq_busy_q  <= seq_busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_bytes_q <= seq_bytes_d;
    seq_len_q   <= seq_len_d;
    seq_idx_q   <= seq_idx_d;
    out_data_q  <= out_data_d;
    out_last_q  <= out_last_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;

  // Sequencer index always points inside the loaded sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_busy_q |-> (LenW'(seq_idx_q) < seq_len_q))
    else $error("sequencer index beyond sequence length");

  // An empty lookup stage never blocks the slave side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lk_valid_q |-> s_tready_o)
    else $error("request refused with empty lookup stage");

  // Bytes of one key leave without gaps once a non-final byte is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tready_i && !m_tlast_o) |=> m_tvalid_o)
    else $error("gap inside a scancode sequence");

endmodule

`default_nettype wire
